/* rtl/tkl_pkg.sv */
// Shared constants, types and control structs for the top-k leaderboard.
`default_nettype none

package tkl_pkg;

  localparam int CAPACITY = 100;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic signed [63:0]  val_t;

  // Cell operation codes.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_CMP  = 2'd1;
  localparam logic [1:0] OP_UPD  = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [1:0] op;
    key_t       key;
    val_t       value;
    idx_t       q_idx;
    logic       q_ok;
    idx_t       pos;
    idx_t       m_idx;
    logic       has_match;
    idx_t       held_new;
  } ctrl_t;

  // Row summary registered by the collector.
  typedef struct packed {
    logic has_match;
    idx_t m_idx;
    logic m_ge;
    idx_t ge_cnt;
    logic rd_hit;
    key_t rd_key;
    val_t rd_value;
  } sum_t;

  function automatic key_t to_key(input logic [31:0] k);
    key_t r;
    r = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (i < 32) begin
        r[i] = k[i % 32];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] from_key(input key_t k);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < KEY_BITS) begin
        r[i] = k[i % KEY_BITS];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tkl_cell.sv */
// One leaderboard slot: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none

module tkl_cell import tkl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire idx_t  idx,
  input  wire ctrl_t ctrl,
  input  wire key_t  left_key,
  input  wire val_t  left_value,
  input  wire key_t  right_key,
  input  wire val_t  right_value,
  output key_t       key,
  output val_t       value,
  output logic       match,
  output logic       ge,
  output logic       sel
);

  key_t key_next;
  val_t value_next;
  logic valid;

  // Slot j of the new list: entries above the insert point close the hole left
  // by a removed key, entries below it move down by one.
  always_comb begin
    key_next   = key;
    value_next = value;
    if (idx == ctrl.pos) begin
      key_next   = ctrl.key;
      value_next = ctrl.value;
    end else if (idx < ctrl.pos) begin
      if (ctrl.has_match && idx >= ctrl.m_idx) begin
        key_next   = right_key;
        value_next = right_value;
      end
    end else begin
      if (!(ctrl.has_match && idx > ctrl.m_idx)) begin
        key_next   = left_key;
        value_next = left_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
      ge    <= 1'b0;
      sel   <= 1'b0;
    end else begin
      if (ctrl.op == OP_CMP) begin
        match <= valid && (key == ctrl.key);
        ge    <= valid && (value >= ctrl.value);
        sel   <= valid && ctrl.q_ok && (idx == ctrl.q_idx);
      end
      if (ctrl.op == OP_UPD) begin
        valid <= idx < ctrl.held_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_UPD) begin
      key   <= key_next;
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/tkl_collect.sv */
// Reduces the per-cell flags to match index, insert count and read data.
`default_nettype none

module tkl_collect import tkl_pkg::*; (
  input  wire logic             clk,
  input  wire logic [CAPACITY-1:0] match,
  input  wire logic [CAPACITY-1:0] ge,
  input  wire logic [CAPACITY-1:0] sel,
  input  wire key_t             keys [CAPACITY],
  input  wire val_t             values [CAPACITY],
  output sum_t                  sum
);

  sum_t sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        sum_next.has_match = 1'b1;
        sum_next.m_idx     = sum_next.m_idx | IDX_W'(i);
        sum_next.m_ge      = sum_next.m_ge | ge[i];
      end
      // Flags are a prefix: the first clear one marks the count.
      if (!ge[i] && (i == 0 || ge[(i + CAPACITY - 1) % CAPACITY])) begin
        sum_next.ge_cnt = sum_next.ge_cnt | IDX_W'(i);
      end
      if (sel[i]) begin
        sum_next.rd_hit   = 1'b1;
        sum_next.rd_key   = sum_next.rd_key | keys[i];
        sum_next.rd_value = sum_next.rd_value | values[i];
      end
    end
    if (ge[CAPACITY-1]) begin
      sum_next.ge_cnt = IDX_W'(CAPACITY);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

`default_nettype wire

/* rtl/top_k_leaderboard_upsert.sv */
// The result passes the compare, collect, plan and commit steps, each registered.
// A new item is taken only after the previous one commits; in_ready rises again with the result, and a
// stalled output holds the commit step until the previous result is taken.
// The row of CAPACITY cells compares every slot at once and shifts every slot at once.
// Reset clears the held entry count and all cell valid bits; no clearing pass is needed.
`default_nettype none

module top_k_leaderboard_upsert import tkl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire logic [31:0]        entry_key,
  input  wire logic signed [63:0] entry_value,
  input  wire logic [6:0]         query_rank,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic [6:0]              result_rank,
  output logic [31:0]             result_key,
  output logic signed [63:0]      result_value,
  output logic [6:0]              entry_count
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  idx_t       held;

  // Held item.
  logic mode_q;
  key_t key_q;
  val_t value_q;
  idx_t q_idx;
  logic q_ok;

  // Plan for the commit step.
  idx_t        pos;
  idx_t        held_new;
  logic        apply;
  logic        found_p;
  logic [6:0]  rank_p;
  logic [31:0] key_p;
  val_t        value_p;

  ctrl_t ctrl;
  sum_t  sum;
  logic  commit;

  key_t              ckey   [CAPACITY];
  val_t              cvalue [CAPACITY];
  logic [CAPACITY-1:0] cmatch;
  logic [CAPACITY-1:0] cge;
  logic [CAPACITY-1:0] csel;

  idx_t n_rm;
  idx_t pos_calc;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    ctrl           = '0;
    ctrl.key       = key_q;
    ctrl.value     = value_q;
    ctrl.q_idx     = q_idx;
    ctrl.q_ok      = q_ok;
    ctrl.pos       = pos;
    ctrl.m_idx     = sum.m_idx;
    ctrl.has_match = sum.has_match;
    ctrl.held_new  = held_new;
    ctrl.op        = OP_NONE;
    if (state == S_CMP) begin
      ctrl.op = OP_CMP;
    end else if (commit && apply) begin
      ctrl.op = OP_UPD;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t lk;
    val_t lv;
    key_t rk;
    val_t rv;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
    end else begin : g_mid_l
      assign lk = ckey[g-1];
      assign lv = cvalue[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_mid_r
      assign rk = ckey[g+1];
      assign rv = cvalue[g+1];
    end
    tkl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(g)),
      .ctrl        (ctrl),
      .left_key    (lk),
      .left_value  (lv),
      .right_key   (rk),
      .right_value (rv),
      .key         (ckey[g]),
      .value       (cvalue[g]),
      .match       (cmatch[g]),
      .ge          (cge[g]),
      .sel         (csel[g])
    );
  end

  tkl_collect u_collect (
    .clk    (clk),
    .match  (cmatch),
    .ge     (cge),
    .sel    (csel),
    .keys   (ckey),
    .values (cvalue),
    .sum    (sum)
  );

  // Remove the old entry first, then insert after every value >= the new one.
  assign n_rm     = held - IDX_W'(sum.has_match);
  assign pos_calc = sum.ge_cnt - IDX_W'(sum.has_match && sum.m_ge);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP:  state <= S_SUM;
        S_SUM:  state <= S_CALC;
        S_CALC: state <= S_DONE;
        S_DONE: begin
          if (commit) begin
            held  <= held_new;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q  <= mode;
      key_q   <= to_key(entry_key);
      value_q <= entry_value;
      q_ok    <= (query_rank != 7'd0) && (32'(query_rank) <= CAPACITY);
      q_idx   <= IDX_W'(query_rank - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      pos <= pos_calc;
      if (mode_q) begin
        apply    <= 1'b0;
        held_new <= held;
        found_p  <= sum.rd_hit;
        rank_p   <= sum.rd_hit ? 7'(q_idx + IDX_W'(1)) : 7'd0;
        key_p    <= sum.rd_hit ? from_key(sum.rd_key) : 32'd0;
        value_p  <= sum.rd_hit ? sum.rd_value : 64'sd0;
      end else if (32'(pos_calc) >= CAPACITY) begin
        // Falls off the end: leave the list alone and echo the beat.
        apply    <= 1'b0;
        held_new <= n_rm;
        found_p  <= 1'b0;
        rank_p   <= 7'd0;
        key_p    <= from_key(key_q);
        value_p  <= value_q;
      end else begin
        apply    <= 1'b1;
        held_new <= (32'(n_rm) < CAPACITY) ? n_rm + IDX_W'(1) : n_rm;
        found_p  <= 1'b1;
        rank_p   <= 7'(pos_calc + IDX_W'(1));
        key_p    <= from_key(key_q);
        value_p  <= value_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found        <= found_p;
      result_rank  <= rank_p;
      result_key   <= key_p;
      result_value <= value_p;
      entry_count  <= 7'(held_new);
    end
  end

endmodule

`default_nettype wire
